// ----- design/all_occurrence_byte_matcher_assert.svh -----
// Assertion shorthands used by the matcher RTL.
`ifndef ALL_OCCURRENCE_BYTE_MATCHER_ASSERT_SVH
`define ALL_OCCURRENCE_BYTE_MATCHER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define AOBM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define AOBM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/aobm_pkg.sv -----
`timescale 1ns / 1ps

package aobm_pkg;

    localparam int unsigned PATTERN_MAX_DEF = 16;
    localparam int unsigned BYTE_W          = 8;
    localparam int unsigned COUNT_W         = 32;
    localparam int unsigned CFG_DATA_W      = 64;
    localparam int unsigned CFG_IDX_W       = 2;
    localparam int unsigned LEN_REG_W       = 5;
    // pattern bytes held in the two 64-bit registers
    localparam int unsigned PAT_LOW_BYTES   = 8;
    localparam int unsigned PAT_REG_BYTES   = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LOW    = 2'd0,
        CFG_PATTERN_HIGH   = 2'd1,
        CFG_PATTERN_LENGTH = 2'd2
    } t_cfg_idx;

endpackage

// ----- design/aobm_window_cmp.sv -----
`timescale 1ns / 1ps

module aobm_window_cmp
    import aobm_pkg::*;
#(
    parameter int unsigned PATTERN_MAX = PATTERN_MAX_DEF
) (
    input  logic [PATTERN_MAX-1:0][BYTE_W-1:0]  i_window,
    input  logic [PATTERN_MAX-1:0][BYTE_W-1:0]  i_pattern,
    input  logic [$clog2(PATTERN_MAX+1)-1:0]    i_length,
    output logic                                o_match
);

    localparam int unsigned IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    logic [PATTERN_MAX-1:0] w_hit;

    // window slot k (0 = newest byte) lines up with pattern byte length-1-k
    always_comb begin
        for (int k = 0; k < PATTERN_MAX; k++) begin
            if (k >= int'(i_length)) begin
                w_hit[k] = 1'b1;
            end else begin
                w_hit[k] = (i_window[k] == i_pattern[IDX_W'(int'(i_length) - 1 - k)]);
            end
        end
    end

    assign o_match = &w_hit;

endmodule

// ----- design/all_occurrence_byte_matcher.sv -----
`timescale 1ns / 1ps
// All-occurrence byte matcher: streams text bytes and reports every start position
// of a configured pattern of up to PATTERN_MAX bytes (sixteen from the registers),
// overlapping matches included, in increasing order. A byte that ends a match, or
// that is marked as the last byte of the text, gives one result item; other bytes
// give none. The last byte's item carries text_done and the total count, after
// which position and count clear. A pattern length of zero matches at every byte.
// Rate: one item per clock cycle while the result side does not stall. An input item
// is held in the input register and its result item in the result register. The full
// window compare is combinational, against the shifted byte history.
// Configure the pattern only while the block is idle.

`include "all_occurrence_byte_matcher_assert.svh"

module all_occurrence_byte_matcher
    import aobm_pkg::*;
#(
    parameter int unsigned PATTERN_MAX = PATTERN_MAX_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // text byte channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [BYTE_W-1:0]     i_text_byte,
    input  logic                  i_last_byte,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_found,
    output logic [COUNT_W-1:0]    o_match_start,
    output logic                  o_text_done,
    output logic [COUNT_W-1:0]    o_match_total
);

    localparam int unsigned LEN_W  = $clog2(PATTERN_MAX + 1);
    localparam int unsigned HIST_D = (PATTERN_MAX > 1) ? PATTERN_MAX - 1 : 1;

    // configuration registers
    logic [CFG_DATA_W-1:0] r_pat_low;
    logic [CFG_DATA_W-1:0] r_pat_high;
    logic [LEN_REG_W-1:0]  r_pat_len;

    // input register
    logic                  r_in_valid;
    logic [BYTE_W-1:0]     r_byte;
    logic                  r_last;

    // search state
    logic [HIST_D-1:0][BYTE_W-1:0] r_hist;
    logic [COUNT_W-1:0]    r_pos;
    logic [COUNT_W-1:0]    r_count;

    // result register
    logic                  r_out_valid;
    logic                  r_found;
    logic [COUNT_W-1:0]    r_start;
    logic                  r_done;
    logic [COUNT_W-1:0]    r_total;

    logic [PATTERN_MAX-1:0][BYTE_W-1:0] w_pattern;
    logic [PATTERN_MAX-1:0][BYTE_W-1:0] w_window;
    logic [LEN_W-1:0]      w_len;
    logic                  w_cmp_match;
    logic                  w_pos_ok;
    logic                  w_found;
    logic                  w_emit;
    logic                  w_out_free;
    logic                  w_advance;
    logic [COUNT_W-1:0]    n_count;
    logic [COUNT_W-1:0]    n_start;

    //------------------------------------------------------------------
    // Configuration: index 3 means nothing and is dropped.
    //------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low  <= '0;
            r_pat_high <= '0;
            r_pat_len  <= '0;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PATTERN_LOW:    r_pat_low  <= i_cfg_wdata;
                CFG_PATTERN_HIGH:   r_pat_high <= i_cfg_wdata;
                CFG_PATTERN_LENGTH: r_pat_len  <= i_cfg_wdata[LEN_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // Unpack pattern bytes; bytes past the two registers read as zero.
    for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_pat
        if (j < PAT_LOW_BYTES) begin : g_low
            assign w_pattern[j] = r_pat_low[BYTE_W*j +: BYTE_W];
        end else if (j < PAT_REG_BYTES) begin : g_high
            assign w_pattern[j] = r_pat_high[BYTE_W*(j-PAT_LOW_BYTES) +: BYTE_W];
        end else begin : g_zero
            assign w_pattern[j] = '0;
        end
    end

    // Clamp the programmed length to what the window can hold.
    assign w_len = (int'(r_pat_len) > PATTERN_MAX) ? LEN_W'(PATTERN_MAX)
                                                   : LEN_W'(r_pat_len);

    //------------------------------------------------------------------
    // Window: slot 0 is the byte under test, then history, newest first.
    //------------------------------------------------------------------
    assign w_window[0] = r_byte;
    for (genvar k = 1; k < PATTERN_MAX; k++) begin : g_win
        assign w_window[k] = r_hist[k-1];
    end

    aobm_window_cmp #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_cmp (
        .i_window  (w_window),
        .i_pattern (w_pattern),
        .i_length  (w_len),
        .o_match   (w_cmp_match)
    );

    // Only slots already written this text may take part: position+1 >= length.
    assign w_pos_ok = ({1'b0, r_pos} + (COUNT_W+1)'(1)) >= (COUNT_W+1)'(w_len);
    assign w_found  = w_pos_ok && w_cmp_match;

    assign n_count = w_found ? r_count + COUNT_W'(1) : r_count;
    // Empty pattern reports the byte's own position.
    assign n_start = !w_found          ? '0 :
                     (w_len == '0)     ? r_pos :
                     r_pos + COUNT_W'(1) - COUNT_W'(w_len);

    //------------------------------------------------------------------
    // Flow control: a quiet byte always advances; a byte with a result
    // advances only when the result register is free or draining.
    //------------------------------------------------------------------
    assign w_emit     = w_found || r_last;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_advance  = r_in_valid && (!w_emit || w_out_free);
    assign o_in_stall = r_in_valid && !w_advance;

    // Input register: take a new item whenever the slot is empty or moving on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_byte <= i_text_byte;
            r_last <= i_last_byte;
        end
    end

    // History shifts on every consumed byte; never reset, reads are gated by position.
    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_hist[0] <= r_byte;
            for (int i = 1; i < HIST_D; i++) begin
                r_hist[i] <= r_hist[i-1];
            end
        end
    end

    // Position and count: clear after the last byte of a text, else advance.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_count <= '0;
        end else if (w_advance) begin
            if (r_last) begin
                r_pos   <= '0;
                r_count <= '0;
            end else begin
                r_pos   <= r_pos + COUNT_W'(1);
                r_count <= n_count;
            end
        end
    end

    //------------------------------------------------------------------
    // Result register
    //------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_emit) begin
            r_found <= w_found;
            r_start <= n_start;
            r_done  <= r_last;
            r_total <= n_count;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_found       = r_found;
    assign o_match_start = r_start;
    assign o_text_done   = r_done;
    assign o_match_total = r_total;

    //------------------------------------------------------------------
    // Assertions
    //------------------------------------------------------------------
    `AOBM_ASSERT_NXT(a_emit_loads_out, i_clk, i_rst_n, w_advance && w_emit, r_out_valid, "result item not registered")
    `AOBM_ASSERT_NXT(a_last_clears, i_clk, i_rst_n, w_advance && r_last, (r_pos == '0) && (r_count == '0), "position or count not cleared after last byte")
    `AOBM_ASSERT_NXT(a_held_item_stays, i_clk, i_rst_n, o_in_stall, r_in_valid && $stable(r_byte) && $stable(r_last), "held item lost or changed")
    `AOBM_ASSERT_IMP(a_nomatch_zero_start, i_clk, i_rst_n, r_out_valid && !r_found, (r_start == '0) && r_done, "quiet result without text_done or with a start")

endmodule

// ----- tb/all_occurrence_byte_matcher_tb.sv -----
`timescale 1ns / 1ps

module all_occurrence_byte_matcher_tb;
    import aobm_pkg::*;

    // Register index 3 has no register behind it: writes there must be dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
    // Extra drain time after the last result; leave margin for quiet items.
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 53;
    localparam int HOLD_CYCLES  = 120;
    localparam int GAP_MAX      = 14;

    // ------------------------------------------------------------------
    // Search predictor and store of expected results
    // ------------------------------------------------------------------
    class match_scoreboard;
        typedef struct packed {
            logic               found;
            logic [COUNT_W-1:0] start;
            logic               done;
            logic [COUNT_W-1:0] total;
        } t_match_result;

        logic [CFG_DATA_W-1:0] pat_low;
        logic [CFG_DATA_W-1:0] pat_high;
        logic [LEN_REG_W-1:0]  pat_len;
        logic [BYTE_W-1:0]     window [PATTERN_MAX_DEF-1];
        logic [COUNT_W-1:0]    position;
        logic [COUNT_W-1:0]    match_count;
        t_match_result         expected_q [$];
        int                    errors;
        int                    checked;
        int                    match_hits;
        int                    texts;

        function new();
            pat_low     = '0;
            pat_high    = '0;
            pat_len     = '0;
            position    = '0;
            match_count = '0;
            foreach (window[i]) window[i] = '0;
            errors     = 0;
            checked    = 0;
            match_hits = 0;
            texts      = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_PATTERN_LOW:    pat_low  = data;
                CFG_PATTERN_HIGH:   pat_high = data;
                CFG_PATTERN_LENGTH: pat_len  = data[LEN_REG_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [BYTE_W-1:0] pattern_byte(int unsigned idx);
            if (idx < PAT_LOW_BYTES)
                return pat_low[BYTE_W*idx +: BYTE_W];
            if (idx < PAT_REG_BYTES)
                return pat_high[BYTE_W*(idx-PAT_LOW_BYTES) +: BYTE_W];
            return '0;
        endfunction

        function void note_input(logic [BYTE_W-1:0] text_byte, logic is_last);
            int unsigned   len;
            logic          hit;
            logic [BYTE_W-1:0] w;
            t_match_result r;
            len = (pat_len > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : pat_len;
            hit = 1'b0;
            r   = '0;
            // compare only once the window holds bytes of this text
            if ({1'b0, position} + 33'd1 >= 33'(len)) begin
                hit = 1'b1;
                for (int k = 0; k < len; k++) begin
                    w = (k == 0) ? text_byte : window[k-1];
                    if (w != pattern_byte(len - 1 - k)) hit = 1'b0;
                end
            end
            if (hit) begin
                match_count = match_count + 1'b1;
                r.start     = (len == 0) ? position : position + 1 - len;
            end
            for (int i = PATTERN_MAX_DEF - 2; i > 0; i--) window[i] = window[i-1];
            window[0] = text_byte;
            if (hit || is_last) begin
                r.found = hit;
                r.done  = is_last;
                r.total = match_count;
                expected_q.push_back(r);
            end
            if (is_last) begin
                position    = '0;
                match_count = '0;
            end else begin
                position = position + 1'b1;
            end
        endfunction

        function void check_result(logic found, logic [COUNT_W-1:0] start,
                                   logic done, logic [COUNT_W-1:0] total);
            t_match_result exp_r;
            checked++;
            if (expected_q.size() == 0) begin
                $error("unexpected result: found=%0b match_start=%0d text_done=%0b match_total=%0d",
                       found, start, done, total);
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            if (exp_r.found) match_hits++;
            if (exp_r.done) texts++;
            if (found !== exp_r.found) begin
                $error("found: expected %0b, got %0b", exp_r.found, found);
                errors++;
            end
            if (start !== exp_r.start) begin
                $error("match_start: expected %0d, got %0d", exp_r.start, start);
                errors++;
            end
            if (done !== exp_r.done) begin
                $error("text_done: expected %0b, got %0b", exp_r.done, done);
                errors++;
            end
            if (total !== exp_r.total) begin
                $error("match_total: expected %0d, got %0d", exp_r.total, total);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Signals and block under test
    // ------------------------------------------------------------------
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    logic [BYTE_W-1:0]     text_byte = '0;
    logic                  last_byte = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  found;
    logic [COUNT_W-1:0]    match_start;
    logic                  text_done;
    logic [COUNT_W-1:0]    match_total;

    match_scoreboard sb = new();

    // pattern bytes of the current setting, used to plant copies in the text
    logic [BYTE_W-1:0] plant_bytes [PAT_REG_BYTES];
    int                plant_len      = 0;
    int                tx_gap_max     = GAP_MAX;
    int                rx_gap_max     = GAP_MAX;
    int                rx_hold_cycles = 0;
    int                items_sent     = 0;
    int                settings_used  = 0;

    all_occurrence_byte_matcher #(
        .PATTERN_MAX (PATTERN_MAX_DEF)
    ) dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_index   (cfg_index),
        .i_cfg_wdata   (cfg_wdata),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_text_byte   (text_byte),
        .i_last_byte   (last_byte),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_found       (found),
        .o_match_start (match_start),
        .o_text_done   (text_done),
        .o_match_total (match_total)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop in case the block hangs or loses results.
    initial begin : watchdog
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // Driving tasks
    // ------------------------------------------------------------------

    // Offer one text item after a random gap; hold it until the block takes it.
    task automatic send_item(input logic [BYTE_W-1:0] b, input logic is_last);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        text_byte <= b;
        last_byte <= is_last;
        do @(posedge clk); while (in_stall !== 1'b0);
        sb.note_input(b, is_last);
        items_sent++;
    endtask

    // Drop valid and wait for every outstanding result; always advance at least one edge
    // so a following raise of valid lands in a later time step.
    task automatic pause_for_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    // Quiet items give no result, so give the pipeline extra cycles to empty.
    task automatic settle();
        pause_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One register write; the caller lowers the enable after the last one.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    task automatic load_pattern(input logic [CFG_DATA_W-1:0] low, input logic [CFG_DATA_W-1:0] high,
                                input logic [LEN_REG_W-1:0] len, input bit poke_spare);
        cfg_write(CFG_PATTERN_LOW, low);
        cfg_write(CFG_PATTERN_HIGH, high);
        cfg_write(CFG_PATTERN_LENGTH, CFG_DATA_W'(len));
        // junk at the unused index must leave every register alone
        if (poke_spare) cfg_write(CFG_IDX_SPARE, {$urandom, $urandom});
        cfg_wr_en <= 1'b0;
        for (int i = 0; i < PAT_REG_BYTES; i++)
            plant_bytes[i] = (i < PAT_LOW_BYTES) ? low[BYTE_W*i +: BYTE_W]
                                                 : high[BYTE_W*(i-PAT_LOW_BYTES) +: BYTE_W];
        plant_len = (len > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : len;
        settings_used++;
    endtask

    // Filler leans on pattern bytes so partial and overlapping matches come up often.
    function automatic logic [BYTE_W-1:0] filler_byte();
        if (plant_len > 0 && $urandom_range(0, 9) < 6)
            return plant_bytes[$urandom_range(0, plant_len - 1)];
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    // Send one text: planted pattern copies (now and then only a tail of one) mixed
    // with filler. A text left open carries its position into the next one.
    task automatic send_text(input int len, input bit close);
        logic [BYTE_W-1:0] queued [$];
        int                from;
        for (int i = 0; i < len; i++) begin
            if (queued.size() == 0) begin
                if (plant_len > 0 && $urandom_range(0, 2) == 0) begin
                    from = ($urandom_range(0, 4) == 0) ? $urandom_range(0, plant_len - 1) : 0;
                    for (int j = from; j < plant_len; j++) queued.push_back(plant_bytes[j]);
                end else begin
                    queued.push_back(filler_byte());
                end
            end
            send_item(queued.pop_front(), close && (i == len - 1));
        end
    endtask

    // Patterns from two letters give periodic shapes with many overlaps.
    function automatic logic [2*CFG_DATA_W-1:0] random_pattern();
        logic [2*CFG_DATA_W-1:0] p;
        logic [BYTE_W-1:0]       a;
        logic [BYTE_W-1:0]       b;
        bit                      two_letter;
        a          = $urandom;
        b          = $urandom;
        two_letter = $urandom_range(0, 1);
        for (int i = 0; i < PAT_REG_BYTES; i++)
            p[BYTE_W*i +: BYTE_W] = two_letter ? ($urandom_range(0, 1) ? a : b)
                                               : BYTE_W'($urandom_range(0, 255));
        return p;
    endfunction

    // Mostly short lengths so matches are frequent; the full range including the
    // values above the limit now and then.
    function automatic logic [LEN_REG_W-1:0] random_length();
        case ($urandom_range(0, 3))
            0, 1:    return LEN_REG_W'($urandom_range(1, 4));
            2:       return LEN_REG_W'($urandom_range(5, 16));
            default: return LEN_REG_W'($urandom_range(0, 31));
        endcase
    endfunction

    function automatic int pick_gap_max();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 3;
            default: return GAP_MAX;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result side: random stall before each item, or one long hold on request
    // ------------------------------------------------------------------
    initial begin : result_sink
        int wait_cycles;
        wait (rst_n === 1'b1);
        forever begin
            if (rx_hold_cycles > 0) begin
                wait_cycles    = rx_hold_cycles;
                rx_hold_cycles = 0;
            end else begin
                wait_cycles = $urandom_range(0, rx_gap_max);
            end
            if (wait_cycles > 0) begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(posedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (out_valid !== 1'b1);
            sb.check_result(found, match_start, text_done, match_total);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [2*CFG_DATA_W-1:0] pat;
        logic [LEN_REG_W-1:0]    len_sel;
        int                      phase_items;
        int                      text_len;
        logic [BYTE_W-1:0]       overlap_text [6];

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Registers still at reset: empty pattern, every byte matches at its own
        // position, the final one together with the done flag.
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h5A, 1'b1);
        settle();

        // Two-byte pattern: no match on the first byte, overlapping matches on a run,
        // two quiet bytes, then a match on the final byte.
        load_pattern(64'h4141, '0, 5'd2, 1'b1);
        overlap_text = '{8'h41, 8'h41, 8'h41, 8'h78, 8'h41, 8'h41};
        for (int i = 0; i < 6; i++) send_item(overlap_text[i], i == 5);
        settle();

        // Full sixteen-byte pattern of extreme byte values, matched exactly once.
        load_pattern(64'h00FF_00FF_FF00_FF00, 64'hFF00_00FF_00FF_FF00, 5'd16, 1'b0);
        for (int i = 0; i < PAT_REG_BYTES; i++) send_item(plant_bytes[i], i == PAT_REG_BYTES - 1);
        settle();

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin
                    pat     = '0;
                    len_sel = '0;
                end
                1: begin
                    // length above the limit acts as sixteen
                    pat     = '1;
                    len_sel = 5'd31;
                end
                default: begin
                    pat     = random_pattern();
                    len_sel = random_length();
                end
            endcase
            load_pattern(pat[CFG_DATA_W-1:0], pat[2*CFG_DATA_W-1:CFG_DATA_W], len_sel,
                         $urandom_range(0, 1));
            tx_gap_max = pick_gap_max();
            rx_gap_max = pick_gap_max();
            if (phase == 0) begin
                // Every byte gives a result: hold the result side off while items
                // keep coming back to back, so the block backs up into its input.
                tx_gap_max     = 0;
                rx_hold_cycles = HOLD_CYCLES;
            end
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                text_len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3)
                                                       : $urandom_range(4, 40);
                send_text(text_len, $urandom_range(0, 7) != 0);
                phase_items += text_len;
                if ($urandom_range(0, 9) == 0) pause_for_results();
            end
            settle();
        end

        $display("Run covered %0d text items under %0d pattern settings,", items_sent,
                 settings_used);
        $display("checking %0d results: %0d matches and %0d closed texts.", sb.checked,
                 sb.match_hits, sb.texts);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+design
design/aobm_pkg.sv
design/aobm_window_cmp.sv
design/all_occurrence_byte_matcher.sv
tb/all_occurrence_byte_matcher_tb.sv
